// ===== rtl/rrts_pkg.sv =====
// Shared types and constants of the repeat transmission scheduler.
package rrts_pkg;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_BASE_REPEATS   = 3'd0;
	localparam logic [2:0] REG_THROTTLE_WIN   = 3'd1;
	localparam logic [2:0] REG_THROTTLE_STR   = 3'd2;
	localparam logic [2:0] REG_REPEAT_FLOOR   = 3'd3;
	localparam logic [2:0] REG_SENDS_PER_TICK = 3'd4;

	// Request codes
	localparam logic [1:0] REQ_ENQ_THROTTLED = 2'd0;
	localparam logic [1:0] REQ_ENQ_EXPLICIT  = 2'd1;
	localparam logic [1:0] REQ_TICK          = 2'd2;
	localparam logic [1:0] REQ_SYNC          = 2'd3;

	// Result kinds
	localparam logic [2:0] KIND_ENQUEUED  = 3'd0;
	localparam logic [2:0] KIND_DROPPED   = 3'd1;
	localparam logic [2:0] KIND_TRANSMIT  = 3'd2;
	localparam logic [2:0] KIND_TICK_IDLE = 3'd3;
	localparam logic [2:0] KIND_SYNC_DONE = 3'd4;

	// Field widths
	localparam int CHAN_W = 7;
	localparam int REPS_W = 16;
	localparam int WIN_W  = 16;
	localparam int STR_W  = 8;
	localparam int PROD_W = WIN_W + STR_W;
	localparam int SEQ_W  = 8;
	localparam int POS_W  = 2;
	localparam int LIM_W  = 5;

	localparam logic [POS_W-1:0]  HOPS        = 2'd3;
	localparam logic [CHAN_W-1:0] CHAN_OFFSET = 7'd2;
	localparam logic [LIM_W-1:0]  MAX_SENDS   = 5'd16;

	typedef struct packed {
		logic [CHAN_W-1:0] chan_a;
		logic [CHAN_W-1:0] chan_b;
		logic [CHAN_W-1:0] chan_c;
		logic [REPS_W-1:0] repeats;
		logic [POS_W-1:0]  pos;
	} entry_t;

endpackage

// ===== rtl/rrts_div.sv =====
// Restoring serial divider, one quotient bit per cycle, for repeat throttling.
module rrts_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rrts_pkg::PROD_W-1:0] dividend,
	input  logic [rrts_pkg::WIN_W-1:0]  divisor,
	output logic                       done,
	output logic [rrts_pkg::PROD_W-1:0] quotient
);
	import rrts_pkg::*;

	localparam int CNT_W = $clog2(PROD_W + 1);

	logic [WIN_W:0]    rem_q;
	logic [PROD_W-1:0] quo_q;
	logic [WIN_W-1:0]  div_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;

	logic [WIN_W:0]    trial;
	logic              fits;

	// One trial subtract per step
	assign trial = {rem_q[WIN_W-1:0], quo_q[PROD_W-1]};
	assign fits  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(PROD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shifts out the top while quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? (trial - {1'b0, div_q}) : trial;
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/radio_repeat_tx_scheduler.sv =====
// Top level of the repeat transmission scheduler: sequencer, queue memory and registers.
//
// Raise start with the request fields while busy is low; the word is taken at that
// edge and busy stays high until the cycle in which the last result is on the ports.
// Results appear one per strobe cycle on result_strobe and cannot be held off;
// last_of_run marks the final one of a request. A throttled enqueue that falls inside
// the throttle window with a nonzero strength waits on the 24-step serial divider;
// a tick does one memory read and one write-back per transmission. Configuration
// writes take effect at once and should only be issued while busy is low.
module radio_repeat_tx_scheduler #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        cfg_write,
	input  logic [2:0]                  cfg_index,
	input  logic [15:0]                 cfg_data,
	input  logic [1:0]                  req_type,
	input  logic [31:0]                 now_ms,
	input  logic [15:0]                 given_repeats,
	input  logic [rrts_pkg::CHAN_W-1:0] hop_chan_a,
	input  logic [rrts_pkg::CHAN_W-1:0] hop_chan_b,
	input  logic [rrts_pkg::CHAN_W-1:0] hop_chan_c,
	input  logic [7:0]                  heard_sequence,
	output logic                        result_strobe,
	output logic [2:0]                  result_kind,
	output logic [2:0]                  queue_slot,
	output logic [7:0]                  seq_value,
	output logic [15:0]                 granted_repeats,
	output logic [rrts_pkg::CHAN_W-1:0] rf_channel,
	output logic                        round_start,
	output logic                        entry_done,
	output logic                        last_of_run
);
	import rrts_pkg::*;

	localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_ENQ     = 9'b000000010,
		S_DIVGO   = 9'b000000100,
		S_DIVWAIT = 9'b000001000,
		S_EMIT    = 9'b000010000,
		S_TICK    = 9'b000100000,
		S_RD      = 9'b001000000,
		S_TX      = 9'b010000000,
		S_SYNC    = 9'b100000000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [REPS_W-1:0] base_q;
	logic [WIN_W-1:0]  window_q;
	logic [STR_W-1:0]  strength_q;
	logic [REPS_W-1:0] floor_q;
	logic [LIM_W-1:0]  sends_q;

	// Scheduler state
	logic [SLOT_W-1:0] head_q;
	logic [CNT_W-1:0]  fill_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [31:0]       prev_ms_q;

	// Captured request word
	logic [1:0]        req_q;
	logic [31:0]       now_q;
	logic [REPS_W-1:0] given_q;
	logic [CHAN_W-1:0] chan_a_q;
	logic [CHAN_W-1:0] chan_b_q;
	logic [CHAN_W-1:0] chan_c_q;
	logic [SEQ_W-1:0]  heard_q;

	// Working registers
	logic [PROD_W-1:0] prod_q;
	logic [REPS_W-1:0] reps_q;
	logic [LIM_W-1:0]  limit_q;
	logic [LIM_W-1:0]  sent_q;

	// Output registers
	logic              strobe_q;
	logic [2:0]        kind_q;
	logic [2:0]        slot_out_q;
	logic [SEQ_W-1:0]  seq_out_q;
	logic [REPS_W-1:0] reps_out_q;
	logic [CHAN_W-1:0] rf_q;
	logic              rs_q;
	logic              done_q;
	logic              last_q;

	// Queue memory
	entry_t            mem_q [QUEUE_DEPTH];
	entry_t            rd_q;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_addr;
	entry_t            mem_wdata;

	// Divider hookup
	logic              div_done;
	logic [PROD_W-1:0] div_quo;

	rrts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_DIVGO),
		.dividend (prod_q),
		.divisor  (window_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Tail slot and head advance
	logic [SUM_W-1:0]  tail_sum;
	logic [SUM_W-1:0]  tail_wrap;
	logic [SLOT_W-1:0] tail_slot;
	logic [SLOT_W-1:0] head_next;

	assign tail_sum  = SUM_W'(head_q) + SUM_W'(fill_q);
	assign tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
		(tail_sum - SUM_W'(QUEUE_DEPTH)) : tail_sum;
	assign tail_slot = tail_wrap[SLOT_W-1:0];
	assign head_next = (head_q == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + SLOT_W'(1);

	// Queue slot numbers are reported in three bits
	logic [SLOT_W+2:0] tail_ext;
	logic [SLOT_W+2:0] head_ext;
	assign tail_ext = {3'b000, tail_slot};
	assign head_ext = {3'b000, head_q};

	logic queue_full;
	assign queue_full = (fill_q == CNT_W'(QUEUE_DEPTH));

	// Throttle decision
	logic [31:0]       elapsed;
	logic [WIN_W-1:0]  win_left;
	logic              do_throttle;
	assign elapsed     = now_q - prev_ms_q;
	assign win_left    = window_q - elapsed[WIN_W-1:0];
	assign do_throttle = (strength_q != '0) && (elapsed < {16'h0000, window_q});

	// Throttled count from the quotient; a reduction at least base leaves base
	logic [REPS_W-1:0] reduced;
	logic [REPS_W-1:0] floored;
	assign reduced = (div_quo < PROD_W'(base_q)) ? (base_q - div_quo[REPS_W-1:0]) : base_q;
	assign floored = (reduced < floor_q) ? floor_q : reduced;

	// Transmission from the head entry
	logic [POS_W-1:0]  tx_pos;
	logic [POS_W-1:0]  tx_pos_inc;
	logic [CHAN_W-1:0] tx_chan;
	logic              tx_round_end;
	logic [REPS_W-1:0] tx_reps;
	logic              tx_done;
	logic [LIM_W-1:0]  sent_inc;
	logic              tx_last;
	entry_t            tx_entry;

	always_comb begin
		tx_pos = (rd_q.pos < HOPS) ? rd_q.pos : '0;
		case (tx_pos)
			2'd0:    tx_chan = rd_q.chan_a;
			2'd1:    tx_chan = rd_q.chan_b;
			default: tx_chan = rd_q.chan_c;
		endcase
		tx_pos_inc   = tx_pos + POS_W'(1);
		tx_round_end = (tx_pos_inc >= HOPS);
		tx_reps      = tx_round_end ? (rd_q.repeats - REPS_W'(1)) : rd_q.repeats;
		tx_done      = tx_round_end && (tx_reps == '0);
		sent_inc     = sent_q + LIM_W'(1);
		tx_last      = (sent_inc == limit_q) || (tx_done && (fill_q == CNT_W'(1)));
		tx_entry         = rd_q;
		tx_entry.pos     = tx_round_end ? '0 : tx_pos_inc;
		tx_entry.repeats = tx_reps;
	end

	// Sync candidate, ahead when within half the sequence space
	logic [SEQ_W-1:0] sync_cand;
	logic [SEQ_W-1:0] sync_diff;
	logic             sync_ahead;
	assign sync_cand  = heard_q + SEQ_W'(1);
	assign sync_diff  = sync_cand - seq_q;
	assign sync_ahead = (sync_diff != '0) && !sync_diff[SEQ_W-1];

	// Memory write port: new entry at tail, or updated head entry
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = head_q;
		mem_wdata = tx_entry;
		if (state_q == S_EMIT && !queue_full) begin
			mem_we            = 1'b1;
			mem_addr          = tail_slot;
			mem_wdata.chan_a  = chan_a_q;
			mem_wdata.chan_b  = chan_b_q;
			mem_wdata.chan_c  = chan_c_q;
			mem_wdata.repeats = reps_q;
			mem_wdata.pos     = '0;
		end else if (state_q == S_TX) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wdata;
		end
		rd_q <= mem_q[head_q];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= 16'd10;
			window_q   <= 16'd200;
			strength_q <= '0;
			floor_q    <= '0;
			sends_q    <= 5'd1;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_BASE_REPEATS:   base_q     <= cfg_data;
				REG_THROTTLE_WIN:   window_q   <= cfg_data;
				REG_THROTTLE_STR:   strength_q <= cfg_data[STR_W-1:0];
				REG_REPEAT_FLOOR:   floor_q    <= cfg_data;
				REG_SENDS_PER_TICK: sends_q    <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (start && state_q == S_IDLE) begin
			now_q    <= now_ms;
			given_q  <= given_repeats;
			chan_a_q <= hop_chan_a;
			chan_b_q <= hop_chan_b;
			chan_c_q <= hop_chan_c;
			heard_q  <= heard_sequence;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			req_q     <= REQ_ENQ_THROTTLED;
			head_q    <= '0;
			fill_q    <= '0;
			seq_q     <= '0;
			prev_ms_q <= '0;
			limit_q   <= '0;
			sent_q    <= '0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req_type;
						case (req_type)
							REQ_ENQ_THROTTLED: state_q <= S_ENQ;
							REQ_ENQ_EXPLICIT:  state_q <= S_ENQ;
							REQ_TICK:          state_q <= S_TICK;
							default:           state_q <= S_SYNC;
						endcase
					end
				end
				S_ENQ: begin
					if (req_q == REQ_ENQ_THROTTLED) begin
						prev_ms_q <= now_q;
						state_q   <= do_throttle ? S_DIVGO : S_EMIT;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_DIVGO: begin
					state_q <= S_DIVWAIT;
				end
				S_DIVWAIT: begin
					if (div_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					strobe_q <= 1'b1;
					if (!queue_full) begin
						seq_q  <= seq_q + SEQ_W'(1);
						fill_q <= fill_q + CNT_W'(1);
					end
					state_q <= S_IDLE;
				end
				S_TICK: begin
					sent_q  <= '0;
					limit_q <= (sends_q > MAX_SENDS) ? MAX_SENDS : sends_q;
					if (sends_q == '0 || fill_q == '0) begin
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_TX;
				end
				S_TX: begin
					strobe_q <= 1'b1;
					sent_q   <= sent_inc;
					if (tx_done) begin
						head_q <= head_next;
						fill_q <= fill_q - CNT_W'(1);
					end
					state_q <= tx_last ? S_IDLE : S_RD;
				end
				S_SYNC: begin
					strobe_q <= 1'b1;
					if (sync_ahead) begin
						seq_q <= sync_cand;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working count for the enqueue
	always_ff @(posedge clk) begin
		if (state_q == S_ENQ) begin
			prod_q <= PROD_W'(win_left) * PROD_W'(strength_q);
			reps_q <= (req_q == REQ_ENQ_THROTTLED) ? base_q : given_q;
		end else if (state_q == S_DIVWAIT && div_done) begin
			reps_q <= floored;
		end
	end

	// Result word
	always_ff @(posedge clk) begin
		case (state_q)
			S_EMIT: begin
				kind_q     <= queue_full ? KIND_DROPPED : KIND_ENQUEUED;
				slot_out_q <= queue_full ? 3'd0 : tail_ext[2:0];
				seq_out_q  <= queue_full ? '0 : seq_q;
				reps_out_q <= queue_full ? '0 : reps_q;
				rf_q       <= '0;
				rs_q       <= 1'b0;
				done_q     <= 1'b0;
				last_q     <= 1'b1;
			end
			S_TICK: begin
				kind_q     <= KIND_TICK_IDLE;
				slot_out_q <= 3'd0;
				seq_out_q  <= '0;
				reps_out_q <= '0;
				rf_q       <= '0;
				rs_q       <= 1'b0;
				done_q     <= 1'b0;
				last_q     <= 1'b1;
			end
			S_TX: begin
				kind_q     <= KIND_TRANSMIT;
				slot_out_q <= head_ext[2:0];
				seq_out_q  <= '0;
				reps_out_q <= '0;
				rf_q       <= tx_chan + CHAN_OFFSET;
				rs_q       <= (tx_pos == '0);
				done_q     <= tx_done;
				last_q     <= tx_last;
			end
			S_SYNC: begin
				kind_q     <= KIND_SYNC_DONE;
				slot_out_q <= 3'd0;
				seq_out_q  <= sync_ahead ? sync_cand : seq_q;
				reps_out_q <= '0;
				rf_q       <= '0;
				rs_q       <= 1'b0;
				done_q     <= 1'b0;
				last_q     <= 1'b1;
			end
			default: ;
		endcase
	end

	assign busy            = (state_q != S_IDLE);
	assign result_strobe   = strobe_q;
	assign result_kind     = kind_q;
	assign queue_slot      = slot_out_q;
	assign seq_value       = seq_out_q;
	assign granted_repeats = reps_out_q;
	assign rf_channel      = rf_q;
	assign round_start     = rs_q;
	assign entry_done      = done_q;
	assign last_of_run     = last_q;

endmodule

// ===== dv/radio_repeat_tx_scheduler_tb.sv =====
// Self-checking testbench for the repeat transmission scheduler, with its own queue predictor.
`timescale 1ns / 100ps

module radio_repeat_tx_scheduler_tb;
	import rrts_pkg::*;

	localparam int DEPTH = 8;
	// index past the last register: writes there must be ignored
	localparam logic [2:0] REG_NONE = 3'd6;

	typedef struct {
		bit [1:0]  op;
		bit [31:0] now;
		bit [15:0] reps;
		bit [6:0]  ch_a;
		bit [6:0]  ch_b;
		bit [6:0]  ch_c;
		bit [7:0]  heard;
	} sched_req_t;

	typedef struct {
		bit [2:0]  kind;
		bit [2:0]  slot;
		bit [7:0]  seq;
		bit [15:0] reps;
		bit [6:0]  rf;
		bit        rs;
		bit        done;
		bit        last;
	} sched_res_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic [1:0]  req_type;
	logic [31:0] now_ms;
	logic [15:0] given_repeats;
	logic [6:0]  hop_chan_a;
	logic [6:0]  hop_chan_b;
	logic [6:0]  hop_chan_c;
	logic [7:0]  heard_sequence;
	logic        result_strobe;
	logic [2:0]  result_kind;
	logic [2:0]  queue_slot;
	logic [7:0]  seq_value;
	logic [15:0] granted_repeats;
	logic [6:0]  rf_channel;
	logic        round_start;
	logic        entry_done;
	logic        last_of_run;

	// predictor copy of registers and queue state
	bit [15:0] cfg_base     = 16'd10;
	bit [15:0] cfg_window   = 16'd200;
	bit [7:0]  cfg_strength = 8'd0;
	bit [15:0] cfg_floor    = 16'd0;
	bit [4:0]  cfg_sends    = 5'd1;
	bit [6:0]  slot_chan [DEPTH][3];
	bit [15:0] slot_reps [DEPTH];
	bit [1:0]  slot_pos  [DEPTH];
	bit [2:0]  head_ptr;
	bit [3:0]  fill_level;
	bit [7:0]  seq_next;
	bit [31:0] last_cmd_ms;

	sched_res_t expected_results[$];
	int         fail_count;
	int         burst_left;

	radio_repeat_tx_scheduler #(.QUEUE_DEPTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_type(req_type),
		.now_ms(now_ms),
		.given_repeats(given_repeats),
		.hop_chan_a(hop_chan_a),
		.hop_chan_b(hop_chan_b),
		.hop_chan_c(hop_chan_c),
		.heard_sequence(heard_sequence),
		.result_strobe(result_strobe),
		.result_kind(result_kind),
		.queue_slot(queue_slot),
		.seq_value(seq_value),
		.granted_repeats(granted_repeats),
		.rf_channel(rf_channel),
		.round_start(round_start),
		.entry_done(entry_done),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Compute the result words one request word causes, and advance the queue state
	task automatic predict_results(input sched_req_t w);
		sched_res_t r;
		sched_res_t run[$];
		bit [15:0]  grant;
		bit [31:0]  elapsed;
		bit [31:0]  cut;
		bit [4:0]   limit;
		bit [2:0]   slot;
		bit [1:0]   p;
		bit [7:0]   cand;
		bit [7:0]   ahead;
		case (w.op)
			REQ_ENQ_THROTTLED, REQ_ENQ_EXPLICIT: begin
				grant = w.reps;
				if (w.op == REQ_ENQ_THROTTLED) begin
					// time is taken even when the word is dropped
					elapsed = w.now - last_cmd_ms;
					last_cmd_ms = w.now;
					grant = cfg_base;
					if (cfg_strength != 0 && elapsed < {16'd0, cfg_window}) begin
						cut = ({16'd0, cfg_window} - elapsed) * {24'd0, cfg_strength}
							/ {16'd0, cfg_window};
						// a reduction reaching the base count leaves the base count
						if (cut < {16'd0, cfg_base})
							grant = cfg_base - cut[15:0];
						if (grant < cfg_floor)
							grant = cfg_floor;
					end
				end
				r = '{default: 0};
				if (fill_level >= DEPTH) begin
					r.kind = KIND_DROPPED;
				end else begin
					slot = 3'(head_ptr + fill_level);
					slot_chan[slot][0] = w.ch_a;
					slot_chan[slot][1] = w.ch_b;
					slot_chan[slot][2] = w.ch_c;
					slot_reps[slot] = grant;
					slot_pos[slot] = 2'd0;
					r.kind = KIND_ENQUEUED;
					r.slot = slot;
					r.seq = seq_next;
					r.reps = grant;
					seq_next++;
					fill_level++;
				end
				run.push_back(r);
			end
			REQ_TICK: begin
				limit = (cfg_sends > MAX_SENDS) ? MAX_SENDS : cfg_sends;
				for (int i = 0; i < limit && fill_level != 0; i++) begin
					slot = head_ptr;
					p = (slot_pos[slot] < HOPS) ? slot_pos[slot] : 2'd0;
					r = '{default: 0};
					r.kind = KIND_TRANSMIT;
					r.slot = slot;
					r.rf = slot_chan[slot][p] + CHAN_OFFSET;
					r.rs = (p == 2'd0);
					p++;
					// end of a round: count down, a zero count wraps and goes on
					if (p >= HOPS) begin
						p = 2'd0;
						slot_reps[slot]--;
						if (slot_reps[slot] == 0) begin
							head_ptr++;
							fill_level--;
							r.done = 1'b1;
						end
					end
					slot_pos[slot] = p;
					run.push_back(r);
				end
				if (run.size() == 0) begin
					r = '{default: 0};
					r.kind = KIND_TICK_IDLE;
					run.push_back(r);
				end
			end
			default: begin
				// advance only when the heard value plus one is ahead modulo 256
				cand = w.heard + 8'd1;
				ahead = cand - seq_next;
				if (ahead >= 8'd1 && ahead <= 8'd127)
					seq_next = cand;
				r = '{default: 0};
				r.kind = KIND_SYNC_DONE;
				r.seq = seq_next;
				run.push_back(r);
			end
		endcase
		run[run.size() - 1].last = 1'b1;
		foreach (run[k])
			expected_results.push_back(run[k]);
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// Compare each result word with the oldest expectation
	always @(posedge clk) begin
		sched_res_t want;
		if (arst_n === 1'b1 && result_strobe === 1'b1) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result word, kind %0h", $time, result_kind);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("result_kind", 32'(want.kind), 32'(result_kind));
				check_field("queue_slot", 32'(want.slot), 32'(queue_slot));
				check_field("seq_value", 32'(want.seq), 32'(seq_value));
				check_field("granted_repeats", 32'(want.reps), 32'(granted_repeats));
				check_field("rf_channel", 32'(want.rf), 32'(rf_channel));
				check_field("round_start", 32'(want.rs), 32'(round_start));
				check_field("entry_done", 32'(want.done), 32'(entry_done));
				check_field("last_of_run", 32'(want.last), 32'(last_of_run));
			end
		end
	end

	// Random word of the given request type; unused fields carry noise
	function automatic sched_req_t noise_word(input bit [1:0] op);
		sched_req_t w;
		w.op = op;
		w.now = $urandom;
		w.reps = 16'($urandom);
		w.ch_a = 7'($urandom_range(0, 127));
		w.ch_b = 7'($urandom_range(0, 127));
		w.ch_c = 7'($urandom_range(0, 127));
		w.heard = 8'($urandom);
		return w;
	endfunction

	// Send one request word; bursts of random length with random gaps between them
	task automatic send_word(input sched_req_t w);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			case ($urandom_range(0, 3))
				0: gap = 0;
				1: gap = $urandom_range(20, 40);
				default: gap = $urandom_range(1, 6);
			endcase
		end
		burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type <= w.op;
		now_ms <= w.now;
		given_repeats <= w.reps;
		hop_chan_a <= w.ch_a;
		hop_chan_b <= w.ch_b;
		hop_chan_c <= w.ch_c;
		heard_sequence <= w.heard;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		predict_results(w);
	endtask

	// Drop start and wait until every result is in and the block is idle
	task automatic settle_idle();
		@(negedge clk);
		start <= 1'b0;
		while (expected_results.size() != 0 || busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		settle_idle();
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_BASE_REPEATS:   cfg_base = data;
			REG_THROTTLE_WIN:   cfg_window = data;
			REG_THROTTLE_STR:   cfg_strength = data[7:0];
			REG_REPEAT_FLOOR:   cfg_floor = data;
			REG_SENDS_PER_TICK: cfg_sends = data[4:0];
			default: ;
		endcase
	endtask

	task automatic send_tick();
		send_word(noise_word(REQ_TICK));
	endtask

	task automatic send_explicit(input bit [15:0] reps, input bit [6:0] a, input bit [6:0] b,
		input bit [6:0] c);
		sched_req_t w;
		w = noise_word(REQ_ENQ_EXPLICIT);
		w.reps = reps;
		w.ch_a = a;
		w.ch_b = b;
		w.ch_c = c;
		send_word(w);
	endtask

	task automatic send_throttled(input bit [31:0] now);
		sched_req_t w;
		w = noise_word(REQ_ENQ_THROTTLED);
		w.now = now;
		send_word(w);
	endtask

	task automatic send_sync(input bit [7:0] heard);
		sched_req_t w;
		w = noise_word(REQ_SYNC);
		w.heard = heard;
		send_word(w);
	endtask

	task automatic drain_queue();
		write_reg(REG_SENDS_PER_TICK, 16'd16);
		while (fill_level != 0)
			send_tick();
	endtask

	// Register defaults after reset, idle tick, syncs ahead and behind, ignored index
	task automatic test_reset_state();
		send_tick();
		send_sync(8'h00);
		send_sync(8'hFF);
		write_reg(REG_NONE, 16'hFFFF);
		send_throttled(32'd0);
	endtask

	// sends_per_tick of zero, above the cap and at the cap
	task automatic test_tick_limit();
		write_reg(REG_SENDS_PER_TICK, 16'd0);
		send_tick();
		write_reg(REG_SENDS_PER_TICK, 16'd31);
		send_tick();
		write_reg(REG_SENDS_PER_TICK, 16'd16);
		send_tick();
		send_tick();
	endtask

	// Channel extremes, including those that wrap past 127
	task automatic test_hop_channels();
		send_explicit(16'd1, 7'd0, 7'd125, 7'd127);
		send_explicit(16'd2, 7'd126, 7'd64, 7'd1);
		send_tick();
	endtask

	// Throttle: full count outside the window, reductions, floor, reduction at or past base, wrap
	task automatic test_throttle();
		write_reg(REG_BASE_REPEATS, 16'd3);
		write_reg(REG_THROTTLE_WIN, 16'd100);
		write_reg(REG_THROTTLE_STR, 16'd2);
		write_reg(REG_REPEAT_FLOOR, 16'd0);
		send_throttled(32'd1000);
		send_throttled(32'd1000);
		send_throttled(32'd1050);
		write_reg(REG_REPEAT_FLOOR, 16'd2);
		send_throttled(32'd1050);
		write_reg(REG_THROTTLE_STR, 16'd255);
		send_throttled(32'd1060);
		send_throttled(32'hFFFF_FFF0);
		send_throttled(32'h0000_0010);
	endtask

	// Full queue drops both kinds of enqueue without using a sequence number
	task automatic test_queue_full();
		while (fill_level < DEPTH)
			send_explicit(16'd1, 7'd10, 7'd20, 7'd30);
		send_explicit(16'hFFFF, 7'd127, 7'd127, 7'd127);
		write_reg(REG_BASE_REPEATS, 16'hFFFF);
		write_reg(REG_REPEAT_FLOOR, 16'hFFFF);
		write_reg(REG_THROTTLE_WIN, 16'hFFFF);
		send_throttled(32'hFFFF_FFFF);
		write_reg(REG_THROTTLE_WIN, 16'd0);
		write_reg(REG_REPEAT_FLOOR, 16'd0);
		write_reg(REG_BASE_REPEATS, 16'd1);
		drain_queue();
		send_throttled(32'd5);
	endtask

	// Sync at equal, at the largest step still ahead, and at exactly half range
	task automatic test_sequence_sync();
		send_sync(seq_next - 8'd1);
		send_sync(seq_next + 8'd126);
		send_sync(seq_next + 8'd127);
	endtask

	// Mixed traffic over several register settings
	task automatic test_random_traffic();
		sched_req_t w;
		int pick;
		for (int phase = 0; phase < 4; phase++) begin
			write_reg(REG_BASE_REPEATS, 16'($urandom_range(1, 4)));
			write_reg(REG_THROTTLE_WIN, 16'((phase == 1) ? 0 : (phase == 3) ? 16'hFFFF
				: $urandom_range(1, 300)));
			write_reg(REG_THROTTLE_STR, 16'((phase == 2) ? 0 : $urandom_range(0, 1)
				? $urandom_range(1, 6) : $urandom_range(7, 255)));
			write_reg(REG_REPEAT_FLOOR, 16'($urandom_range(0, 3)));
			case (phase)
				0: write_reg(REG_SENDS_PER_TICK, 16'd1);
				1: write_reg(REG_SENDS_PER_TICK, 16'($urandom_range(2, 15)));
				2: write_reg(REG_SENDS_PER_TICK, 16'd16);
				default: write_reg(REG_SENDS_PER_TICK, 16'($urandom_range(17, 31)));
			endcase
			for (int n = 0; n < 100; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 25) begin
					w = noise_word(REQ_ENQ_EXPLICIT);
					// large counts only where they are dropped
					if (fill_level < DEPTH)
						w.reps = 16'($urandom_range(1, 4));
				end else if (pick < 50) begin
					w = noise_word(REQ_ENQ_THROTTLED);
					if ($urandom_range(0, 4) != 0)
						w.now = last_cmd_ms + $urandom_range(0, 2 * cfg_window + 2);
				end else if (pick < 90) begin
					w = noise_word(REQ_TICK);
				end else begin
					w = noise_word(REQ_SYNC);
				end
				send_word(w);
			end
		end
	endtask

	// Zero repeat count wraps after its first round; left for last as it never drains
	task automatic test_zero_repeats();
		drain_queue();
		send_explicit(16'd0, 7'd3, 7'd4, 7'd5);
		write_reg(REG_BASE_REPEATS, 16'd0);
		write_reg(REG_THROTTLE_STR, 16'd0);
		send_throttled($urandom);
		send_explicit(16'h8000, 7'd90, 7'd91, 7'd92);
		send_tick();
		send_tick();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_type = '0;
		now_ms = '0;
		given_repeats = '0;
		hop_chan_a = '0;
		hop_chan_b = '0;
		hop_chan_c = '0;
		heard_sequence = '0;
		fail_count = 0;
		burst_left = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_tick_limit();
		test_hop_channels();
		test_throttle();
		test_queue_full();
		test_sequence_sync();
		test_random_traffic();
		test_zero_repeats();

		settle_idle();
		repeat (64) @(posedge clk);
		if (fail_count == 0)
			$display("radio_repeat_tx_scheduler_tb: done, clean");
		else
			$display("radio_repeat_tx_scheduler_tb: done, errors");
		$finish;
	end

	// Run time limit
	initial begin
		#5_000_000;
		$display("radio_repeat_tx_scheduler_tb: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/rrts_pkg.sv
rtl/rrts_div.sv
rtl/radio_repeat_tx_scheduler.sv
dv/radio_repeat_tx_scheduler_tb.sv
